FILE: rtl/core/heater_resistance_calc_macros.svh
// Assertion helpers shared by the heater resistance block.
// All checks sample on the rising edge of clk_i and are off while rst_ni is low.
`ifndef HEATER_RESISTANCE_CALC_MACROS_SVH
`define HEATER_RESISTANCE_CALC_MACROS_SVH

`define HRC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that applies only while a result is presented on the output channel.
`define HRC_ASSERT_OUT(name, cond, msg) \
  `HRC_ASSERT(name, out_valid_o |-> (cond), msg)

`endif

FILE: rtl/core/hrc_pkg.sv
`timescale 1ns / 1ps

package hrc_pkg;

  localparam int unsigned CUR_SCALE   = 10;
  localparam logic [15:0] SAT16       = 16'hFFFF;
  localparam int unsigned BATT_SHIFT  = 10;
  localparam int unsigned CMD_GAIN    = 125;
  localparam int unsigned RES_SHIFT   = 13;
  localparam int unsigned ROUND_HALF  = 62;
  localparam int unsigned ORDER_SPLIT = 524287;

  // floor(x / 125) == (x * RECIP_125) >> RECIP_SHIFT for every x below 2^32 / 79.
  localparam int unsigned RECIP_125   = 34359739;
  localparam int unsigned RECIP_SHIFT = 32;

  // Smallest divider quotient whose rounded division by 125 exceeds 16 bits.
  localparam int unsigned SMALL_SAT_Q = 8191938;

  localparam int unsigned NUM_W     = 27;
  localparam int unsigned N_W       = 25;
  localparam int unsigned RECIP_W   = 26;
  localparam int unsigned PROD_W    = N_W + RECIP_W;
  localparam int unsigned X_W       = 23;
  localparam int unsigned PROD2_W   = X_W + RECIP_W;
  localparam int unsigned THRESH_W  = 20;

  localparam int unsigned DIV_W              = 32;
  localparam int unsigned DIVISOR_W          = 16;
  localparam int unsigned Q1_W               = DIV_W - RES_SHIFT;
  localparam int unsigned DIV_BITS_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES         = DIV_W / DIV_BITS_PER_STAGE;

  typedef struct packed {
    logic [15:0] cmd;
    logic [15:0] cur;
    logic        ok;
    logic        big;
  } side_t;

endpackage

FILE: rtl/core/hrc_div.sv
`timescale 1ns / 1ps

module hrc_div import hrc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [DIV_W-1:0]     dividend_i,
  input  logic [DIVISOR_W-1:0] divisor_i,
  input  side_t                side_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DIV_W-1:0]     quotient_o,
  output side_t                side_o
);

  localparam int unsigned Last = DIV_STAGES - 1;

  logic [DIV_STAGES-1:0] valid_q;
  logic [DIV_STAGES-1:0] en;
  logic [DIV_W-1:0]      word_q [DIV_STAGES];
  logic [DIVISOR_W-1:0]  rem_q  [DIV_STAGES];
  logic [DIVISOR_W-1:0]  dvs_q  [DIV_STAGES];
  side_t                 side_q [DIV_STAGES];

  // A stage takes new data when it is empty or when its own content moves on.
  always_comb begin
    en[Last] = !valid_q[Last] || out_ready_i;
    for (int s = Last - 1; s >= 0; s--) begin
      en[s] = !valid_q[s] || en[s+1];
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic                 v_in;
    logic [DIV_W-1:0]     w_in;
    logic [DIVISOR_W-1:0] r_in;
    logic [DIVISOR_W-1:0] d_in;
    side_t                s_in;
    logic [DIV_W-1:0]     word_d;
    logic [DIVISOR_W-1:0] rem_d;

    if (s == 0) begin : g_first
      assign v_in = in_valid_i;
      assign w_in = dividend_i;
      assign r_in = '0;
      assign d_in = divisor_i;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = valid_q[s-1];
      assign w_in = word_q[s-1];
      assign r_in = rem_q[s-1];
      assign d_in = dvs_q[s-1];
      assign s_in = side_q[s-1];
    end

    // Restoring division: the dividend shifts out at the top while
    // quotient bits shift in at the bottom.
    always_comb begin
      logic [DIVISOR_W:0] t;
      word_d = w_in;
      rem_d  = r_in;
      for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
        t = {rem_d, word_d[DIV_W-1]};
        if (t >= {1'b0, d_in}) begin
          rem_d  = DIVISOR_W'(t - {1'b0, d_in});
          word_d = {word_d[DIV_W-2:0], 1'b1};
        end else begin
          rem_d  = t[DIVISOR_W-1:0];
          word_d = {word_d[DIV_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en[s]) begin
        valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s] && v_in) begin
        word_q[s] <= word_d;
        rem_q[s]  <= rem_d;
        dvs_q[s]  <= d_in;
        side_q[s] <= s_in;
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[Last];
  assign quotient_o  = word_q[Last];
  assign side_o      = side_q[Last];

endmodule

FILE: rtl/core/heater_resistance_calc.sv
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// cfg       cfg_valid_i / cfg_ready_o  cfg_data_i (min_heater_current)
// in        in_valid_i / in_ready_o    current_raw_i, command_voltage_i, battery_voltage_i
// out       out_valid_o / out_ready_i  ecu_voltage_o, heater_current_o,
//                                      heater_resistance_o, resistance_times_four_o
//
// One request per cycle is taken and one result per cycle is delivered while the output is not stalled.
// The pipeline registers hold, in order: scaling, the reciprocal multiply by 1/125, eight divider
// stages of four quotient bits each, the second 1/125 multiply and the output register.
// Reset clears the stage valid bits and the current threshold; the config port is always ready.
// A stage holds while the stage after it is full and blocked, and empty stages close up.

module heater_resistance_calc import hrc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        current_raw_i,
  input  logic [15:0]        command_voltage_i,
  input  logic signed [15:0] battery_voltage_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        ecu_voltage_o,
  output logic [15:0]        heater_current_o,
  output logic [15:0]        heater_resistance_o,
  output logic [15:0]        resistance_times_four_o
);

`include "heater_resistance_calc_macros.svh"

  logic [THRESH_W-1:0] thresh_q;

  logic en_a, en_b, en_d, en_e;

  // Stage A: current scaling, threshold and numerator.
  logic [THRESH_W-1:0] cur_prod;
  logic [15:0]         cur_a;
  logic [X_W-1:0]      cmd_prod;
  logic [NUM_W-1:0]    num_a;
  side_t               side_a;
  logic                a_valid_q;
  side_t               a_side_q;
  logic [N_W-1:0]      a_n_q;

  // Stage B: rounding of the numerator by 125 for the large case.
  logic [PROD_W-1:0]   prod_b;
  side_t               side_b;
  logic                b_valid_q;
  side_t               b_side_q;
  logic [PROD_W-1:0]   b_prod_q;
  logic [Q1_W-1:0]     b_n_q;
  logic [DIV_W-1:0]    dividend;

  // Divider.
  logic                div_in_ready;
  logic                div_valid;
  logic [DIV_W-1:0]    div_quot;
  side_t               div_side;

  // Stage D: rounding of the quotient by 125 for the small case.
  logic [X_W-1:0]      x_d;
  logic                d_valid_q;
  side_t               d_side_q;
  logic [PROD2_W-1:0]  d_prod_q;
  logic [15:0]         d_lo_q;
  logic                d_hi_q;
  logic                d_ssat_q;

  // Stage E: selection and saturation.
  logic                sat_e;
  logic [15:0]         res_e;
  logic                out_valid_q;
  logic [15:0]         ecu_q, cur_q, res_q, res4_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= '0;
    end else if (cfg_valid_i) begin
      thresh_q <= THRESH_W'(cfg_data_i * CUR_SCALE);
    end
  end

  assign en_e       = !out_valid_q || out_ready_i;
  assign en_d       = !d_valid_q || en_e;
  assign en_b       = !b_valid_q || div_in_ready;
  assign en_a       = !a_valid_q || en_b;
  assign in_ready_o = en_a;

  always_comb begin
    cur_prod   = THRESH_W'(current_raw_i) * THRESH_W'(CUR_SCALE);
    cur_a      = (|cur_prod[THRESH_W-1:16]) ? SAT16 : cur_prod[15:0];
    cmd_prod   = X_W'(command_voltage_i) * X_W'(CMD_GAIN);
    num_a      = ({{(NUM_W-16){battery_voltage_i[15]}}, battery_voltage_i} << BATT_SHIFT)
                 - NUM_W'(cmd_prod);
    side_a.cmd = command_voltage_i;
    side_a.cur = cur_a;
    side_a.ok  = (THRESH_W'(cur_a) > thresh_q) && !num_a[NUM_W-1];
    side_a.big = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_a) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && in_valid_i) begin
      a_side_q <= side_a;
      a_n_q    <= num_a[N_W-1:0];
    end
  end

  always_comb begin
    side_b     = a_side_q;
    side_b.big = a_n_q >= N_W'(ORDER_SPLIT);
    prod_b     = PROD_W'(a_n_q + N_W'(ROUND_HALF)) * PROD_W'(RECIP_125);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en_b) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b && a_valid_q) begin
      b_side_q <= side_b;
      b_prod_q <= prod_b;
      b_n_q    <= a_n_q[Q1_W-1:0];
    end
  end

  // Large numerators are rounded by 125 before the division by the current,
  // small ones after it.
  assign dividend = b_side_q.big ? {b_prod_q[RECIP_SHIFT +: Q1_W], {RES_SHIFT{1'b0}}}
                                 : {b_n_q, {RES_SHIFT{1'b0}}};

  hrc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_valid_q),
    .in_ready_o  (div_in_ready),
    .dividend_i  (dividend),
    .divisor_i   (b_side_q.cur),
    .side_i      (b_side_q),
    .out_valid_o (div_valid),
    .out_ready_i (en_d),
    .quotient_o  (div_quot),
    .side_o      (div_side)
  );

  // Past the saturation point x_d wraps, which is harmless since its product is then unused.
  assign x_d = X_W'(div_quot + DIV_W'(ROUND_HALF));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (en_d) begin
      d_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_d && div_valid) begin
      d_side_q <= div_side;
      d_prod_q <= PROD2_W'(x_d) * PROD2_W'(RECIP_125);
      d_lo_q   <= div_quot[15:0];
      d_hi_q   <= |div_quot[DIV_W-1:16];
      d_ssat_q <= div_quot >= DIV_W'(SMALL_SAT_Q);
    end
  end

  always_comb begin
    if (!d_side_q.ok) begin
      sat_e = 1'b0;
      res_e = '0;
    end else if (d_side_q.big) begin
      sat_e = d_hi_q;
      res_e = d_lo_q;
    end else begin
      sat_e = d_ssat_q;
      res_e = d_prod_q[RECIP_SHIFT +: 16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_e) begin
      out_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_e && d_valid_q) begin
      ecu_q  <= d_side_q.cmd;
      cur_q  <= d_side_q.cur;
      res_q  <= sat_e ? SAT16 : res_e;
      res4_q <= (sat_e || (|res_e[15:14])) ? SAT16 : {res_e[13:0], 2'b00};
    end
  end

  assign out_valid_o             = out_valid_q;
  assign ecu_voltage_o           = ecu_q;
  assign heater_current_o        = cur_q;
  assign heater_resistance_o     = res_q;
  assign resistance_times_four_o = res4_q;

  // The input side can only block when every stage is full and the output is stalled.
  `HRC_ASSERT(a_backpressure_only_when_stalled, !in_ready_o |-> (out_valid_o && !out_ready_i),
              "input blocked while the pipeline can still move")
  `HRC_ASSERT_OUT(a_zero_current_no_resistance,
                  (heater_current_o == 16'd0) |-> (heater_resistance_o == 16'd0),
                  "resistance reported for a zero current")
  `HRC_ASSERT_OUT(a_times_four_consistent,
                  (heater_resistance_o < 16'd16384) |->
                  (resistance_times_four_o == (heater_resistance_o << 2)),
                  "times-four output does not match the resistance")
  `HRC_ASSERT_OUT(a_times_four_saturates,
                  (heater_resistance_o >= 16'd16384) |-> (resistance_times_four_o == SAT16),
                  "times-four output not saturated for a large resistance")

endmodule

FILE: sim/heater_resistance_calc_test.sv
`timescale 1ns / 1ps

module heater_resistance_calc_test;

  localparam int unsigned CURRENT_SCALE   = 10;
  localparam int unsigned SAT_MAX         = 65535;
  localparam int          BATT_GAIN       = 1024;
  localparam int          CMD_GAIN        = 125;
  localparam int unsigned RES_SCALE       = 8192;
  localparam int unsigned ROUND_DIV       = 125;
  localparam int unsigned ROUND_HALF      = 62;
  localparam int unsigned ORDER_SPLIT     = 524287;
  localparam int unsigned TIMES_FOUR      = 4;
  localparam int          SETTLE_CYCLES   = 20;
  localparam int          WATCHDOG_LIMIT  = 5000;
  localparam int          ITEMS_PER_PHASE = 180;
  localparam int          LONG_STALL      = 80;
  localparam int          REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [15:0]        current_raw;
    logic [15:0]        command_voltage;
    logic signed [15:0] battery_voltage;
  } heater_sample_t;

  typedef struct packed {
    logic [15:0] ecu_voltage;
    logic [15:0] heater_current;
    logic [15:0] heater_resistance;
    logic [15:0] resistance_times_four;
  } heater_reading_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [15:0]        current_raw_i = '0;
  logic [15:0]        command_voltage_i = '0;
  logic signed [15:0] battery_voltage_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [15:0]        ecu_voltage_o;
  logic [15:0]        heater_current_o;
  logic [15:0]        heater_resistance_o;
  logic [15:0]        resistance_times_four_o;

  heater_sample_t  pending_samples[$];
  heater_reading_t expected_readings[$];
  logic [15:0]     min_current_cfg = '0;
  logic            in_accepted = 1'b0;
  logic            cfg_taken = 1'b0;
  int              bad_readings = 0;

  heater_resistance_calc u_dut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_ready_o             (cfg_ready_o),
    .cfg_data_i              (cfg_data_i),
    .in_valid_i              (in_valid_i),
    .in_ready_o              (in_ready_o),
    .current_raw_i           (current_raw_i),
    .command_voltage_i       (command_voltage_i),
    .battery_voltage_i       (battery_voltage_i),
    .out_valid_o             (out_valid_o),
    .out_ready_i             (out_ready_i),
    .ecu_voltage_o           (ecu_voltage_o),
    .heater_current_o        (heater_current_o),
    .heater_resistance_o     (heater_resistance_o),
    .resistance_times_four_o (resistance_times_four_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] clamp16(longint unsigned v);
    return (v > SAT_MAX) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic heater_reading_t calc_reading(heater_sample_t s, logic [15:0] min_cur);
    heater_reading_t r;
    longint unsigned cur;
    longint unsigned thresh;
    longint          num;
    longint unsigned n;
    longint unsigned res;
    cur    = 64'(clamp16(longint'(s.current_raw) * CURRENT_SCALE));
    thresh = longint'(min_cur) * CURRENT_SCALE;
    res    = 0;
    if (cur > thresh) begin
      num = longint'(s.battery_voltage) * BATT_GAIN - longint'(s.command_voltage) * CMD_GAIN;
      if (num >= 0) begin
        n = num;
        // Large numerators round by 125 first so the product stays small.
        if (n >= ORDER_SPLIT) begin
          n   = (n + ROUND_HALF) / ROUND_DIV;
          res = (n * RES_SCALE) / cur;
        end else begin
          n   = (n * RES_SCALE) / cur;
          res = (n + ROUND_HALF) / ROUND_DIV;
        end
      end
    end
    r.ecu_voltage           = s.command_voltage;
    r.heater_current        = cur[15:0];
    r.heater_resistance     = clamp16(res);
    r.resistance_times_four = clamp16(res * TIMES_FOUR);
    return r;
  endfunction

  function automatic heater_sample_t random_sample(logic [15:0] min_cur);
    heater_sample_t s;
    int             mode;
    int             raw;
    int             target;
    int             cmd;
    mode = $urandom_range(0, 9);
    s.current_raw     = 16'($urandom_range(0, 65535));
    s.command_voltage = 16'($urandom_range(0, 65535));
    s.battery_voltage = 16'($urandom_range(0, 65535));
    case (mode)
      4, 5: begin
        // Current right around the configured minimum.
        raw = int'(min_cur) + int'($urandom_range(0, 4)) - 2;
        if (raw < 0) raw = 0;
        if (raw > 65535) raw = 65535;
        s.current_raw     = 16'(raw);
        s.command_voltage = 16'($urandom_range(0, 2000));
        s.battery_voltage = 16'($urandom_range(0, 32767));
      end
      6: begin
        // Numerator on either side of the point where the operation order flips.
        cmd    = $urandom_range(0, 65535);
        target = int'(ORDER_SPLIT) + int'($urandom_range(0, 2047)) - 1024;
        s.command_voltage = 16'(cmd);
        s.battery_voltage = 16'((target + cmd * CMD_GAIN) / BATT_GAIN);
        s.current_raw     = 16'($urandom_range(1, 6553));
      end
      7: begin
        s.current_raw     = 16'($urandom_range(1, 50));
        s.command_voltage = 16'($urandom_range(0, 4000));
        s.battery_voltage = 16'($urandom_range(0, 32767));
      end
      8: begin
        s.current_raw     = 16'($urandom_range(0, 6553));
        s.battery_voltage = 16'($urandom_range(0, 32767));
      end
      9: begin
        s.current_raw     = 16'($urandom_range(6553, 65535));
        s.battery_voltage = 16'($urandom_range(0, 32767));
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic add_sample(int raw, int cmd, int batt);
    heater_sample_t s;
    s.current_raw     = 16'(raw);
    s.command_voltage = 16'(cmd);
    s.battery_voltage = 16'(batt);
    pending_samples.push_back(s);
  endtask

  task automatic add_random_phase(logic [15:0] min_cur);
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      pending_samples.push_back(random_sample(min_cur));
    end
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || expected_readings.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_min_current(logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 1'b0;
  endtask

  // Request driver: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_accepted)) begin
      if (in_accepted) pending_samples.delete(0);
      if (gap_left > 0 || pending_samples.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid_i <= 1'b0;
      end else begin
        current_raw_i     <= pending_samples[0].current_raw;
        command_voltage_i <= pending_samples[0].command_voltage;
        battery_voltage_i <= pending_samples[0].battery_voltage;
        in_valid_i        <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // Receiver: a stall pattern picked at random from three modes, plus a long hold-off
  // now and then while requests are being offered, so the pipeline backs up.
  int rx_cycle = 0;
  int rx_mode = 0;
  int stall_left = 0;
  int since_stall = 700;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_cycle++;
      since_stall++;
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 2);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (since_stall >= 800 && in_valid_i) begin
        stall_left  = LONG_STALL;
        since_stall = 0;
        out_ready_i <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(0, 1) == 1);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  heater_reading_t seen_reading;
  heater_reading_t want_reading;
  heater_sample_t  taken_sample;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_accepted <= in_valid_i && in_ready_o;
      cfg_taken   <= cfg_valid_i && cfg_ready_o;
      if (cfg_valid_i && cfg_ready_o) min_current_cfg <= cfg_data_i;
      if (out_valid_o && out_ready_i) begin
        seen_reading.ecu_voltage           = ecu_voltage_o;
        seen_reading.heater_current        = heater_current_o;
        seen_reading.heater_resistance     = heater_resistance_o;
        seen_reading.resistance_times_four = resistance_times_four_o;
        if (expected_readings.size() == 0) begin
          bad_readings++;
          if (bad_readings <= REPORT_LIMIT) begin
            $display("unexpected result: ecu %0d cur %0d res %0d res4 %0d",
                     ecu_voltage_o, heater_current_o, heater_resistance_o,
                     resistance_times_four_o);
          end
        end else begin
          want_reading = expected_readings.pop_front();
          if (seen_reading.ecu_voltage !== want_reading.ecu_voltage ||
              seen_reading.heater_current !== want_reading.heater_current ||
              seen_reading.heater_resistance !== want_reading.heater_resistance ||
              seen_reading.resistance_times_four !== want_reading.resistance_times_four) begin
            bad_readings++;
            if (bad_readings <= REPORT_LIMIT) begin
              $display("mismatch: ecu %0d/%0d cur %0d/%0d res %0d/%0d res4 %0d/%0d (exp/got)",
                       want_reading.ecu_voltage, seen_reading.ecu_voltage,
                       want_reading.heater_current, seen_reading.heater_current,
                       want_reading.heater_resistance, seen_reading.heater_resistance,
                       want_reading.resistance_times_four,
                       seen_reading.resistance_times_four);
            end
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        taken_sample.current_raw     = current_raw_i;
        taken_sample.command_voltage = command_voltage_i;
        taken_sample.battery_voltage = battery_voltage_i;
        expected_readings.push_back(calc_reading(taken_sample, min_current_cfg));
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL heater_resistance_calc");
        $finish;
      end
    end
  end

  logic [15:0] phase_min[] = '{16'd65535, 16'd1, 16'd6553, 16'd1000, 16'd0, 16'd37, 16'd0};

  initial begin
    // Directed requests, run with the minimum current at its reset value of zero.
    add_sample(0, 0, 0);
    add_sample(65535, 65535, 32767);
    add_sample(65535, 65535, -32768);
    add_sample(1, 0, 32767);
    add_sample(6553, 0, 32767);
    add_sample(6554, 0, 1000);
    add_sample(100, 213, 538);      // numerator exactly at the order split
    add_sample(100, 426, 564);      // numerator one below the split
    add_sample(100, 1024, 125);     // numerator exactly zero
    add_sample(100, 1, 0);          // numerator slightly negative
    add_sample(100, 0, -1);
    add_sample(1, 65535, 32767);
    add_sample(50, 0, 600);
    add_sample(200, 100, 16000);
    add_sample(3000, 20000, 4000);
    add_sample(1000, 100, 2000);
    add_sample(1000, 0, 3000);      // resistance fits, four times it saturates
    add_sample(16'hAAAA, 16'h5555, 16'h5555);
    add_sample(16'h5555, 16'hAAAA, -21846);
    add_sample(1, 0, 1);
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();
    add_random_phase(16'd0);
    wait_idle();
    phase_min[4] = 16'($urandom_range(0, 6600));
    foreach (phase_min[p]) begin
      write_min_current(phase_min[p]);
      // A few directed requests around the new threshold.
      add_sample(int'(phase_min[p]), 0, 32767);
      add_sample((phase_min[p] == 16'hFFFF) ? 16'hFFFF : phase_min[p] + 1, 0, 32767);
      add_random_phase(phase_min[p]);
      wait_idle();
    end
    if (bad_readings == 0 && expected_readings.size() == 0) begin
      $display("PASS heater_resistance_calc");
    end else begin
      $display("FAIL heater_resistance_calc");
    end
    $finish;
  end

endmodule
